// File: src/cwbc_pkg.sv
// Shared constants, types and codes for the color white-balance classifier.
package cwbc_pkg;

  // Width of one pulse count and of the stored white reference
  localparam int COUNT_WIDTH = 16;
  // 255 * count needs eight more bits than the count
  localparam int SCALE_BITS = 8;
  localparam int DIV_WIDTH = COUNT_WIDTH + SCALE_BITS;
  localparam int STEP_WIDTH = $clog2(DIV_WIDTH);

  localparam int LEVEL_WIDTH = 16;
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;
  localparam int COLOR_WIDTH = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_WIDTH = ((3 * COUNT_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 3 * LEVEL_WIDTH + COLOR_WIDTH;
  localparam int OUT_TDATA_WIDTH = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [COLOR_WIDTH-1:0] {
    COLOR_RED   = 2'd0,
    COLOR_GREEN = 2'd1,
    COLOR_BLUE  = 2'd2
  } color_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DONE
  } seq_state_t;

  // Control from the sequencer to the divider lanes and output stage
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } lane_ctrl_t;

endpackage

// File: src/cwbc_div_lane.sv
// Bit-serial restoring divider lane: level = sat(floor(255 * count / reference)).
module cwbc_div_lane
  import cwbc_pkg::*;
(
  input  logic                   clk,
  input  lane_ctrl_t             ctrl,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [COUNT_WIDTH-1:0] divisor,
  output logic [LEVEL_WIDTH-1:0] level
);

  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [DIV_WIDTH-1:0]   quo_r, quo_nxt;
  logic [COUNT_WIDTH-1:0] div_r, div_nxt;
  logic [COUNT_WIDTH:0]   rem_shift;
  logic [COUNT_WIDTH:0]   div_ext;
  logic [COUNT_WIDTH:0]   rem_diff;
  logic                   q_bit;

  // Bring down one dividend bit and try the subtract
  assign rem_shift = {rem_r, quo_r[DIV_WIDTH-1]};
  assign div_ext   = {1'b0, div_r};
  assign q_bit     = (rem_shift >= div_ext);
  assign rem_diff  = rem_shift - div_ext;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    div_nxt = div_r;
    if (ctrl.load) begin
      // 255 * count as (count << 8) - count
      rem_nxt = '0;
      quo_nxt = {count, SCALE_BITS'(0)} - DIV_WIDTH'(count);
      div_nxt = divisor;
    end else if (ctrl.step) begin
      rem_nxt = q_bit ? rem_diff[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
      quo_nxt = {quo_r[DIV_WIDTH-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  // Saturate on a zero reference or an oversize quotient
  always_comb begin
    if (div_r == '0) begin
      level = LEVEL_MAX;
    end else if (quo_r > DIV_WIDTH'(LEVEL_MAX)) begin
      level = LEVEL_MAX;
    end else begin
      level = quo_r[LEVEL_WIDTH-1:0];
    end
  end

endmodule

// File: src/cwbc_seq.sv
// Sequencer: loads the lanes, counts the divide steps and hands off the result.
module cwbc_seq
  import cwbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       out_free,
  output lane_ctrl_t ctrl,
  output logic       in_ready
);

  seq_state_t             state_r, state_nxt;
  logic [STEP_WIDTH-1:0]  step_cnt_r, step_cnt_nxt;
  logic                   last_step;

  assign last_step = (step_cnt_r == STEP_WIDTH'(DIV_WIDTH - 1));

  // Next state
  always_comb begin
    state_nxt    = state_r;
    step_cnt_nxt = step_cnt_r;
    case (state_r)
      SEQ_IDLE: begin
        if (in_fire) begin
          state_nxt    = SEQ_RUN;
          step_cnt_nxt = '0;
        end
      end
      SEQ_RUN: begin
        step_cnt_nxt = step_cnt_r + STEP_WIDTH'(1);
        if (last_step) begin
          state_nxt = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (out_free) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.step   = 1'b0;
    ctrl.finish = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_fire;
      end
      SEQ_RUN: begin
        ctrl.step = 1'b1;
      end
      SEQ_DONE: begin
        ctrl.finish = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_cnt_r <= step_cnt_nxt;
  end

endmodule

// File: src/color_white_balance_classifier_core.sv
// An accepted item is loaded into the lanes, divided bit-serially at one quotient bit per cycle, and its result
// is then registered to out_tvalid. A new item is taken only once the last result has left the divider;
// three divider lanes run side by side.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, rst_n low): drops the white reference, the next item recalibrates,
// and clears the output valid.
module color_white_balance_classifier_core
  import cwbc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata: red_count, blue_count, green_count (lowest bits first)
  input  logic [IN_TDATA_WIDTH-1:0]  in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // out_tdata: red_level, green_level, blue_level, dominant_color, zero pad
  output logic [OUT_TDATA_WIDTH-1:0] out_tdata,
  // out_tuser: was_calibration
  output logic                       out_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready
);

  lane_ctrl_t             ctrl;
  logic                   in_fire;
  logic                   out_free;
  logic [COUNT_WIDTH-1:0] red_count, blue_count, green_count;
  logic [COUNT_WIDTH-1:0] red_div, blue_div, green_div;
  logic [LEVEL_WIDTH-1:0] red_level, green_level, blue_level;
  logic [LEVEL_WIDTH-1:0] best_level;
  color_t                 dominant;

  logic                   calibrated_r;
  logic                   cal_item_r;
  logic [COUNT_WIDTH-1:0] ref_red_r, ref_blue_r, ref_green_r;
  logic [OUT_TDATA_WIDTH-1:0] out_tdata_r;
  logic                   out_tuser_r;
  logic                   out_tvalid_r;

  assign red_count   = in_tdata[COUNT_WIDTH-1:0];
  assign blue_count  = in_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
  assign green_count = in_tdata[3*COUNT_WIDTH-1:2*COUNT_WIDTH];

  assign in_fire  = in_tvalid & in_tready;
  assign out_free = ~out_tvalid_r | out_tready;

  cwbc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ctrl     (ctrl),
    .in_ready (in_tready)
  );

  // The first item divides by itself
  assign red_div   = calibrated_r ? ref_red_r   : red_count;
  assign blue_div  = calibrated_r ? ref_blue_r  : blue_count;
  assign green_div = calibrated_r ? ref_green_r : green_count;

  cwbc_div_lane u_lane_red (
    .clk (clk), .ctrl (ctrl), .count (red_count), .divisor (red_div), .level (red_level)
  );
  cwbc_div_lane u_lane_green (
    .clk (clk), .ctrl (ctrl), .count (green_count), .divisor (green_div),
    .level (green_level)
  );
  cwbc_div_lane u_lane_blue (
    .clk (clk), .ctrl (ctrl), .count (blue_count), .divisor (blue_div),
    .level (blue_level)
  );

  // Store the white reference on the first item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calibrated_r <= 1'b0;
    end else if (ctrl.load) begin
      calibrated_r <= 1'b1;
    end
    if (ctrl.load) begin
      cal_item_r <= ~calibrated_r;
      if (!calibrated_r) begin
        ref_red_r   <= red_count;
        ref_blue_r  <= blue_count;
        ref_green_r <= green_count;
      end
    end
  end

  // Pick the dominant channel: red wins ties with green, blue must be strictly larger
  always_comb begin
    if (red_level < green_level) begin
      best_level = green_level;
      dominant   = COLOR_GREEN;
    end else begin
      best_level = red_level;
      dominant   = COLOR_RED;
    end
    if (best_level < blue_level) begin
      dominant = COLOR_BLUE;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (ctrl.finish) begin
      out_tdata_r <= OUT_TDATA_WIDTH'({dominant, blue_level, green_level, red_level});
      out_tuser_r <= cal_item_r;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tvalid = out_tvalid_r;

endmodule

// File: src/cwbc_checker.sv
// Port-level checker for the classifier core and its bind statement.
module cwbc_checker
  import cwbc_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [OUT_TDATA_WIDTH-1:0] out_tdata,
  input logic                       out_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready
);

  logic seen_out_r;

  // Track whether a result has left since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_out_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      seen_out_r <= 1'b1;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // One item at a time: ready drops after an accept
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  // Only the first result after reset is the calibration item
  a_first_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !seen_out_r |-> out_tuser)
    else $error("first result not marked as calibration");

  a_later_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && seen_out_r |-> !out_tuser)
    else $error("later result marked as calibration");

  // Dominant color code is always red, green or blue
  a_dom_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3*LEVEL_WIDTH+COLOR_WIDTH-1:3*LEVEL_WIDTH] != 2'd3)
    else $error("dominant color code out of range");

endmodule

bind color_white_balance_classifier_core cwbc_checker u_cwbc_checker (.*);
